/* hw/rtl/urt_pkg.sv */
// ----------------------------------------------------------------------------
// urt_pkg
// Shared constants, types and helpers of the distinct row table.
// ----------------------------------------------------------------------------
package urt_pkg;

  localparam int TableDepth = 256;
  localparam int IdxW       = 8;             // entry index width
  localparam int FillW      = IdxW + 1;      // entry count, 0 .. TableDepth
  localparam int MaxCols    = 8;
  localparam int CodeW      = 8;
  localparam int RowW       = MaxCols * CodeW;
  localparam int HitW       = 16;
  localparam int ColW       = 4;             // num_columns register width

  localparam logic [ColW-1:0]  NumColsRst = ColW'(MaxCols);
  localparam logic [CodeW-1:0] MissingRst = CodeW'(99);

  // configuration register indexes
  localparam logic CfgNumCols = 1'b0;
  localparam logic CfgMissing = 1'b1;

  typedef enum logic {
    OpInsert = 1'b0,
    OpRead   = 1'b1
  } op_e;

  // one item travelling down the cell chain
  typedef struct packed {
    logic             vld;
    op_e              op;
    logic [RowW-1:0]  codes;    // insert row, or the stored row once read
    logic [IdxW-1:0]  rd_idx;
    logic             done;     // matched or claimed a cell
    logic [IdxW-1:0]  idx;
    logic             is_new;
    logic [HitW-1:0]  hits;
  } query_t;

  typedef struct packed {
    logic             vld;
    logic [IdxW-1:0]  entry_index;
    logic             is_new;
    logic             full;
    logic             bad;
    logic [RowW-1:0]  shifted;
    logic [HitW-1:0]  hits;
    logic [FillW-1:0] unique_cnt;
  } result_t;

  // zero acts as one column, values above the maximum as the maximum
  function automatic logic [ColW-1:0] active_cols(input logic [ColW-1:0] n);
    if (n == '0) begin
      return ColW'(1);
    end else if (n > ColW'(MaxCols)) begin
      return ColW'(MaxCols);
    end
    return n;
  endfunction

  function automatic logic [RowW-1:0] col_mask(input logic [ColW-1:0] n);
    logic [RowW-1:0] m;
    m = '0;
    for (int c = 0; c < MaxCols; c++) begin
      if (ColW'(c) < n) begin
        m[c*CodeW +: CodeW] = '1;
      end
    end
    return m;
  endfunction

endpackage

/* hw/rtl/urt_cell.sv */
// ----------------------------------------------------------------------------
// urt_cell
// One table entry: stored row and hit count, with the match, append and read
// logic for the item passing through it. Registers the item for the next cell.
// ----------------------------------------------------------------------------
module urt_cell import urt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic [IdxW-1:0]  cell_idx_i,
  input  logic [FillW-1:0] fill_i,
  input  logic [RowW-1:0]  mask_i,
  input  query_t           q_i,
  output query_t           q_o,
  output logic             claim_o
);

  logic [RowW-1:0] pat_q;
  logic [HitW-1:0] cnt_q;
  query_t          q_q, q_d;

  logic            ins_open, occupied, hit, claim, rd;
  logic [HitW-1:0] cnt_inc;

  assign ins_open = q_i.vld && (q_i.op == OpInsert) && !q_i.done;
  assign occupied = {1'b0, cell_idx_i} < fill_i;
  assign hit      = ins_open && occupied && ((pat_q & mask_i) == q_i.codes);
  // entries fill in order, so the first free cell is the one at the fill count
  assign claim    = ins_open && ({1'b0, cell_idx_i} == fill_i);
  assign rd       = q_i.vld && (q_i.op == OpRead) && (q_i.rd_idx == cell_idx_i);
  assign cnt_inc  = (&cnt_q) ? cnt_q : cnt_q + HitW'(1);

  always_comb begin
    q_d = q_i;
    if (hit) begin
      q_d.done = 1'b1;
      q_d.idx  = cell_idx_i;
      q_d.hits = cnt_inc;
    end else if (claim) begin
      q_d.done   = 1'b1;
      q_d.idx    = cell_idx_i;
      q_d.is_new = 1'b1;
      q_d.hits   = HitW'(1);
    end else if (rd) begin
      q_d.codes = pat_q;
      q_d.hits  = cnt_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (hit) begin
        cnt_q <= cnt_inc;
      end else if (claim) begin
        pat_q <= q_i.codes;
        cnt_q <= HitW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q <= '0;
    end else if (adv_i) begin
      q_q <= q_d;
    end
  end

  assign q_o     = q_q;
  assign claim_o = claim;

endmodule

/* hw/rtl/urt_tail.sv */
// ----------------------------------------------------------------------------
// urt_tail
// End of the cell chain: column minimum tracking, entry count, the shift of
// read rows and the result register.
// ----------------------------------------------------------------------------
module urt_tail import urt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic [ColW-1:0]  ncols_i,
  input  logic [CodeW-1:0] missing_i,
  input  query_t           q_i,
  output result_t          res_o
);

  logic [CodeW-1:0] min_q [MaxCols];
  logic [CodeW-1:0] min_d [MaxCols];
  logic [MaxCols-1:0] seen_q, seen_d;
  logic [FillW-1:0]   entry_q, entry_d;
  result_t            res_q, res_d;
  logic               commit_new;
  logic [CodeW-1:0]   b;

  assign commit_new = adv_i && q_i.vld && (q_i.op == OpInsert) && q_i.done && q_i.is_new;

  always_comb begin
    res_d            = '0;
    res_d.vld        = q_i.vld;
    res_d.unique_cnt = entry_q;
    b                = '0;
    unique case (q_i.op)
      OpInsert: begin
        if (q_i.done) begin
          res_d.entry_index = q_i.idx;
          res_d.is_new      = q_i.is_new;
          res_d.hits        = q_i.hits;
          if (q_i.is_new) begin
            res_d.unique_cnt = entry_q + FillW'(1);
          end
        end else begin
          res_d.full = 1'b1;
        end
      end
      OpRead: begin
        res_d.entry_index = q_i.rd_idx;
        if ({1'b0, q_i.rd_idx} >= entry_q) begin
          res_d.bad = 1'b1;
        end else begin
          res_d.hits = q_i.hits;
          for (int c = 0; c < MaxCols; c++) begin
            b = q_i.codes[c*CodeW +: CodeW];
            if (ColW'(c) < ncols_i) begin
              if (b != missing_i && seen_q[c]) begin
                res_d.shifted[c*CodeW +: CodeW] = b - min_q[c];
              end else begin
                res_d.shifted[c*CodeW +: CodeW] = b;
              end
            end
          end
        end
      end
      default: res_d.vld = q_i.vld;
    endcase
  end

  // minimum over stored rows, missing codes left out
  always_comb begin
    min_d   = min_q;
    seen_d  = seen_q;
    entry_d = entry_q;
    if (commit_new) begin
      entry_d = entry_q + FillW'(1);
      for (int c = 0; c < MaxCols; c++) begin
        if (ColW'(c) < ncols_i
            && q_i.codes[c*CodeW +: CodeW] != missing_i
            && (!seen_q[c]
                || $signed(q_i.codes[c*CodeW +: CodeW]) < $signed(min_q[c]))) begin
          min_d[c]  = q_i.codes[c*CodeW +: CodeW];
          seen_d[c] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < MaxCols; c++) begin
        min_q[c] <= '0;
      end
      seen_q  <= '0;
      entry_q <= '0;
      res_q   <= '0;
    end else begin
      min_q   <= min_d;
      seen_q  <= seen_d;
      entry_q <= entry_d;
      if (adv_i) begin
        res_q <= res_d;
      end
    end
  end

  assign res_o = res_q;

endmodule

/* hw/rtl/unique_row_table_with_counts_unit.sv */
// ----------------------------------------------------------------------------
// unique_row_table_with_counts_unit
// Distinct row table with saturating occurrence counts. Every table entry is a
// cell in a chain of 256; an item enters the first cell and moves one cell per
// cycle while the chain advances, matching, appending to or reading the entry
// it passes, then leaves through a tail stage that applies the column minimum
// shift. One beat is accepted per cycle while the chain advances; its result
// is registered by each of the 256 cells in turn and then by the tail result
// register. Items never overtake, so results keep order.
// The whole chain stalls while the result register holds an untaken beat.
// ----------------------------------------------------------------------------
module unique_row_table_with_counts_unit import urt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CodeW-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             op_i,
  input  logic [RowW-1:0]  row_codes_i,
  input  logic [IdxW-1:0]  read_index_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [IdxW-1:0]  entry_index_o,
  output logic             is_new_o,
  output logic             table_full_o,
  output logic             bad_index_o,
  output logic [RowW-1:0]  shifted_codes_o,
  output logic [HitW-1:0]  hit_count_o,
  output logic [FillW-1:0] unique_count_o
);

  logic [ColW-1:0]  num_cols_q, ncols;
  logic [CodeW-1:0] missing_q;
  logic [RowW-1:0]  mask;
  logic [FillW-1:0] fill_q;
  logic             adv;
  logic [TableDepth-1:0] claims;
  query_t           chain [TableDepth+1];
  result_t          res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_cols_q <= NumColsRst;
      missing_q  <= MissingRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgNumCols: num_cols_q <= cfg_wdata_i[ColW-1:0];
        CfgMissing: missing_q  <= cfg_wdata_i;
        default:    missing_q  <= missing_q;
      endcase
    end
  end

  assign ncols = active_cols(num_cols_q);
  assign mask  = col_mask(ncols);
  assign adv   = !res.vld || out_ready_i;

  always_comb begin
    chain[0]        = '0;
    chain[0].vld    = in_valid_i;
    chain[0].op     = op_e'(op_i);
    chain[0].codes  = row_codes_i & mask;
    chain[0].rd_idx = read_index_i;
  end

  for (genvar k = 0; k < TableDepth; k++) begin : g_cell
    urt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .adv_i      (adv),
      .cell_idx_i (IdxW'(k)),
      .fill_i     (fill_q),
      .mask_i     (mask),
      .q_i        (chain[k]),
      .q_o        (chain[k+1]),
      .claim_o    (claims[k])
    );
  end

  // cells taken so far, counted as items claim them inside the chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (adv && |claims) begin
      fill_q <= fill_q + FillW'(1);
    end
  end

  urt_tail u_tail (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .ncols_i   (ncols),
    .missing_i (missing_q),
    .q_i       (chain[TableDepth]),
    .res_o     (res)
  );

  assign in_ready_o      = adv;
  assign out_valid_o     = res.vld;
  assign entry_index_o   = res.entry_index;
  assign is_new_o        = res.is_new;
  assign table_full_o    = res.full;
  assign bad_index_o     = res.bad;
  assign shifted_codes_o = res.shifted;
  assign hit_count_o     = res.hits;
  assign unique_count_o  = res.unique_cnt;

  a_new_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_new_o |-> !table_full_o && !bad_index_o)
    else $error("new entry beat also flags full or bad index");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && table_full_o |-> unique_count_o == FillW'(TableDepth))
    else $error("table full reported below capacity");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_index_o |-> hit_count_o == '0 && shifted_codes_o == '0)
    else $error("bad index beat carries data");

  a_fill_ahead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q >= unique_count_o)
    else $error("chain fill count behind delivered entry count");

endmodule

/* tb/tb_unique_row_table_with_counts_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_unique_row_table_with_counts_unit
// Drives insert and read beats into the distinct row table through random
// idle and stall bursts, predicts every result from its own copy of the
// table, counts and column minima, and checks each result field by field.
// ----------------------------------------------------------------------------
module tb_unique_row_table_with_counts_unit import urt_pkg::*; ();

  localparam int CycleLimit = 1_000_000;
  localparam int PoolSize   = 16;

  typedef struct packed {
    logic [IdxW-1:0]  entry;
    logic             is_new;
    logic             full;
    logic             bad;
    logic [RowW-1:0]  shifted;
    logic [HitW-1:0]  hits;
    logic [FillW-1:0] uniq;
  } table_answer_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic             cfg_idx_i;
  logic [CodeW-1:0] cfg_wdata_i;
  logic             in_valid_i;
  logic             in_ready_o;
  logic             op_i;
  logic [RowW-1:0]  row_codes_i;
  logic [IdxW-1:0]  read_index_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [IdxW-1:0]  entry_index_o;
  logic             is_new_o;
  logic             table_full_o;
  logic             bad_index_o;
  logic [RowW-1:0]  shifted_codes_o;
  logic [HitW-1:0]  hit_count_o;
  logic [FillW-1:0] unique_count_o;

  // predicted table state
  logic [RowW-1:0]  stored_rows [TableDepth];
  logic [HitW-1:0]  stored_hits [TableDepth];
  int               fill_level;
  logic [CodeW-1:0] col_floor [MaxCols];
  bit               col_seen [MaxCols];
  logic [ColW-1:0]  cur_cols;
  logic [CodeW-1:0] cur_missing;

  table_answer_t    answers_due [$];
  logic [RowW-1:0]  row_pool [PoolSize];
  int               n_errors;
  int               cycle_cnt;
  bit               idle_on;
  int               hold_len;

  unique_row_table_with_counts_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .row_codes_i     (row_codes_i),
    .read_index_i    (read_index_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .entry_index_o   (entry_index_o),
    .is_new_o        (is_new_o),
    .table_full_o    (table_full_o),
    .bad_index_o     (bad_index_o),
    .shifted_codes_o (shifted_codes_o),
    .hit_count_o     (hit_count_o),
    .unique_count_o  (unique_count_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // computes the result of one beat and updates the table copy
  function automatic table_answer_t lookup_row_table(input op_e op,
                                                     input logic [RowW-1:0] codes,
                                                     input logic [IdxW-1:0] ridx);
    table_answer_t    a;
    int               ncol;
    int               c;
    int               j;
    int               k;
    bit               hit;
    logic [RowW-1:0]  mask;
    logic [RowW-1:0]  row;
    logic [CodeW-1:0] b;
    a    = '0;
    ncol = (cur_cols == '0) ? 1 : ((cur_cols > MaxCols) ? MaxCols : int'(cur_cols));
    mask = '0;
    for (c = 0; c < ncol; c++) mask[c*CodeW +: CodeW] = '1;
    if (op == OpInsert) begin
      row = codes & mask;
      hit = 1'b0;
      k   = 0;
      for (j = 0; j < fill_level; j++) begin
        if (!hit && (stored_rows[j] & mask) == row) begin
          hit = 1'b1;
          k   = j;
        end
      end
      if (hit) begin
        if (stored_hits[k] != '1) stored_hits[k]++;
        a.entry = IdxW'(k);
        a.hits  = stored_hits[k];
      end else if (fill_level < TableDepth) begin
        k              = fill_level;
        stored_rows[k] = row;
        stored_hits[k] = HitW'(1);
        fill_level++;
        for (c = 0; c < ncol; c++) begin
          b = row[c*CodeW +: CodeW];
          // missing codes never move the column floor
          if (b != cur_missing && (!col_seen[c] || $signed(b) < $signed(col_floor[c]))) begin
            col_floor[c] = b;
            col_seen[c]  = 1'b1;
          end
        end
        a.entry  = IdxW'(k);
        a.is_new = 1'b1;
        a.hits   = HitW'(1);
      end else begin
        a.full = 1'b1;
      end
    end else begin
      a.entry = ridx;
      if (int'(ridx) >= fill_level) begin
        a.bad = 1'b1;
      end else begin
        for (c = 0; c < ncol; c++) begin
          b = stored_rows[ridx][c*CodeW +: CodeW];
          if (b != cur_missing && col_seen[c]) b = b - col_floor[c];
          a.shifted[c*CodeW +: CodeW] = b;
        end
        a.hits = stored_hits[ridx];
      end
    end
    a.uniq = FillW'(fill_level);
    return a;
  endfunction

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      if (n_errors < 50) begin
        $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
      end
      n_errors++;
    end
  endtask

  always @(posedge clk_i) begin : result_check
    table_answer_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (answers_due.size() == 0) begin
        $display("%0t ns: unexpected result beat, expected none, got entry_index %h",
                 $time, entry_index_o);
        n_errors++;
      end else begin
        want = answers_due.pop_front();
        check_field("entry_index", want.entry, entry_index_o);
        check_field("is_new", want.is_new, is_new_o);
        check_field("table_full", want.full, table_full_o);
        check_field("bad_index", want.bad, bad_index_o);
        check_field("shifted_codes", want.shifted, shifted_codes_o);
        check_field("hit_count", want.hits, hit_count_o);
        check_field("unique_count", want.uniq, unique_count_o);
      end
    end
  end

  // result side: random stall bursts, plus one long hold when asked
  initial begin : receiver
    int len;
    out_ready_i = 1'b1;
    forever begin
      @(posedge clk_i);
      len = 0;
      if (hold_len != 0) begin
        len      = hold_len;
        hold_len = 0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        len = $urandom_range(1, 13);
      end
      if (len != 0) begin
        out_ready_i <= 1'b0;
        repeat (len) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_item(input op_e op, input logic [RowW-1:0] codes,
                           input logic [IdxW-1:0] ridx);
    table_answer_t ans;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    op_i         <= op;
    row_codes_i  <= codes;
    read_index_i <= ridx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    ans = lookup_row_table(op, codes, ridx);
    answers_due.insert(answers_due.size(), ans);
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (answers_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(input logic idx, input logic [CodeW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == CfgNumCols) cur_cols = value[ColW-1:0];
    else cur_missing = value;
  endtask

  // only the low nibble counts for the column register
  task automatic reconfigure(input logic [ColW-1:0] cols, input logic [CodeW-1:0] missing);
    drain();
    write_register(CfgNumCols, {4'($urandom_range(0, 15)), cols});
    write_register(CfgMissing, missing);
  endtask

  function automatic logic [CodeW-1:0] odd_code();
    case ($urandom_range(0, 5))
      0:       return cur_missing;
      1:       return 8'h80;
      2:       return 8'h7f;
      3:       return 8'h00;
      default: return CodeW'($urandom);
    endcase
  endfunction

  function automatic logic [RowW-1:0] pick_row();
    logic [RowW-1:0] r;
    int              c;
    if ($urandom_range(0, 3) != 0) return row_pool[$urandom_range(0, PoolSize - 1)];
    for (c = 0; c < MaxCols; c++) r[c*CodeW +: CodeW] = odd_code();
    return r;
  endfunction

  task automatic random_item(input int read_pct);
    logic [IdxW-1:0] ridx;
    int              top;
    top = (fill_level < TableDepth) ? fill_level : TableDepth - 1;
    if (fill_level != 0 && $urandom_range(0, 4) != 0) ridx = IdxW'($urandom_range(0, top));
    else ridx = IdxW'($urandom);
    if ($urandom_range(1, 100) <= read_pct) send_item(OpRead, {$urandom, $urandom}, ridx);
    else send_item(OpInsert, pick_row(), ridx);
  endtask

  // extremes, duplicates, missing codes and a column that has never been seen
  task automatic test_directed_rows;
    int i;
    send_item(OpInsert, 64'h63_01_7f_80_ff_05_fb_00, '0);
    send_item(OpRead, '0, 8'd0);
    // column 7 still unseen once 99 stops being the missing code
    reconfigure(4'd8, 8'h05);
    send_item(OpRead, '1, 8'd0);
    reconfigure(NumColsRst, MissingRst);
    send_item(OpInsert, 64'h0, '0);
    send_item(OpInsert, 64'h0, '1);
    send_item(OpInsert, {8{8'h7f}}, '0);
    send_item(OpInsert, {8{8'h80}}, '0);
    send_item(OpInsert, {8{8'hff}}, '0);
    send_item(OpInsert, {8{8'h55}}, '0);
    send_item(OpInsert, {8{8'haa}}, '0);
    send_item(OpInsert, 64'h63_00_63_63_63_63_00_63, '0);
    send_item(OpInsert, {8{8'h80}}, '0);
    for (i = 0; i <= 8; i++) send_item(OpRead, '0, IdxW'(i));
    send_item(OpRead, '0, 8'd255);
  endtask

  task automatic test_column_settings;
    reconfigure(4'd1, MissingRst);
    // entries 0 and 1 both start with a zero code: the lower one wins
    send_item(OpInsert, 64'hdead_beef_1234_5600, '0);
    send_item(OpInsert, 64'h0123_4567_89ab_cd42, '0);
    send_item(OpRead, '0, 8'd9);
    reconfigure(4'd0, MissingRst);
    send_item(OpInsert, 64'hffff_ffff_ffff_ff42, '0);
    send_item(OpRead, '0, 8'd3);
    reconfigure(4'd15, MissingRst);
    send_item(OpInsert, 64'h42, '0);
    send_item(OpInsert, 64'h1, '0);
    send_item(OpRead, '0, 8'd9);
    send_item(OpRead, '0, 8'd10);
    reconfigure(4'd3, 8'h80);
    send_item(OpInsert, 64'hffff_ffff_ff80_8010, '0);
    send_item(OpRead, '0, 8'd3);
    send_item(OpRead, '0, 8'd4);
    send_item(OpRead, '0, 8'd11);
    reconfigure(4'd3, 8'h7f);
    send_item(OpRead, '0, 8'd2);
    send_item(OpInsert, 64'h7f_7f_7f, '0);
    reconfigure(NumColsRst, MissingRst);
  endtask

  task automatic test_random_mix;
    int seg;
    int i;
    logic [ColW-1:0]  cols;
    logic [CodeW-1:0] missing;
    for (i = 0; i < PoolSize; i++) row_pool[i] = {$urandom, $urandom};
    for (seg = 0; seg < 6; seg++) begin
      case ($urandom_range(0, 5))
        0:       cols = 4'd0;
        1:       cols = 4'd15;
        2:       cols = 4'd1;
        default: cols = ColW'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 4))
        0:       missing = 8'h80;
        1:       missing = 8'h7f;
        2:       missing = MissingRst;
        default: missing = CodeW'($urandom);
      endcase
      reconfigure(cols, missing);
      for (i = 0; i < PoolSize; i++) begin
        if ($urandom_range(0, 1) == 0) row_pool[i] = pick_row();
      end
      idle_on = ($urandom_range(0, 3) != 0);
      for (i = 0; i < 120; i++) random_item(30);
    end
    idle_on = 1'b1;
  endtask

  task automatic test_table_fill;
    int i;
    reconfigure(4'd8, CodeW'($urandom));
    while (fill_level < TableDepth) send_item(OpInsert, {$urandom, $urandom}, '0);
    for (i = 0; i < 8; i++) send_item(OpInsert, {$urandom, $urandom}, '0);
    send_item(OpInsert, stored_rows[TableDepth-1], '0);
    send_item(OpRead, '0, 8'd255);
    send_item(OpRead, '0, 8'd0);
    for (i = 0; i < 10; i++) random_item(40);
  endtask

  // long result hold so the chain backs up into the input
  task automatic test_backpressure;
    int i;
    drain();
    idle_on  = 1'b0;
    hold_len = 700;
    for (i = 0; i < 400; i++) random_item(40);
    idle_on = 1'b1;
  endtask

  task automatic test_random_when_full;
    int i;
    reconfigure(ColW'($urandom_range(1, 8)), CodeW'($urandom));
    for (i = 0; i < 250; i++) random_item(40);
  endtask

  // one stored row sent back to back, each beat raising the same count
  task automatic test_repeated_row;
    logic [RowW-1:0] row;
    int              k;
    int              i;
    reconfigure(4'd8, MissingRst);
    idle_on = 1'b0;
    k       = $urandom_range(0, fill_level - 1);
    row     = stored_rows[k];
    for (i = 0; i < 40; i++) send_item(OpInsert, row, '0);
    send_item(OpRead, '0, IdxW'(k));
  endtask

  task automatic test_steady_stream;
    int i;
    for (i = 0; i < 150; i++) random_item(35);
  endtask

  initial begin
    int c;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CfgNumCols;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    op_i         = OpInsert;
    row_codes_i  = '0;
    read_index_i = '0;
    n_errors     = 0;
    cycle_cnt    = 0;
    idle_on      = 1'b1;
    hold_len     = 0;
    fill_level   = 0;
    cur_cols     = NumColsRst;
    cur_missing  = MissingRst;
    for (c = 0; c < MaxCols; c++) begin
      col_floor[c] = '0;
      col_seen[c]  = 1'b0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_rows();
    test_column_settings();
    test_random_mix();
    test_table_fill();
    test_backpressure();
    test_random_when_full();
    test_repeated_row();
    test_steady_stream();

    drain();
    repeat (300) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
